[rtl/core/bba_pkg.sv]
// Buddy block allocator: shared command and status codes and sequencer states.
// No dependencies.
package bba_pkg;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_BLOCK  = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_ASRCH  = 13'b0000000000010,
		S_APOPW  = 13'b0000000000100,
		S_ASPLIT = 13'b0000000001000,
		S_FLVL   = 13'b0000000010000,
		S_FMERGE = 13'b0000000100000,
		S_FRMRD  = 13'b0000001000000,
		S_FRMCMP = 13'b0000010000000,
		S_FSHRD  = 13'b0000100000000,
		S_FSHWR  = 13'b0001000000000,
		S_FMFIN  = 13'b0010000000000,
		S_DONE   = 13'b0100000000000,
		S_SPARE  = 13'b1000000000000
	} seq_state_t;

endpackage

[rtl/core/bba_list_ram.sv]
// Free-list slot memory: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module bba_list_ram #(
	parameter int DEPTH = 255,
	parameter int AW = 8,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/buddy_block_allocator_unit.sv]
// Buddy block allocator top level: sequencer, node flags, list lengths, output register.
// Depends on bba_pkg and bba_list_ram.
//
// Usage: requests arrive on the input channel (in_valid/in_stall) carrying
// command, request_bytes and block_offset; one result per request leaves on
// the output channel (out_valid/out_stall) as result_offset, status and
// bytes_in_use. A transfer happens when valid is high and stall is low.
// The block takes one request at a time; in_stall stays high from the cycle
// after a transfer until the result is loaded into the output register.
// The search, split and level walks move one level per cycle; each merge step
// scans that level's free list through the single read port of the slot memory.
// A finished result waits in the output register while out_stall is high;
// the next request is taken meanwhile and runs until its own result is due.
// Reset (arst_n low) returns the tree to one free root block and clears the
// byte total; the slot memory needs no clearing.
module buddy_block_allocator_unit #(
	parameter int LEVELS = 8,
	parameter int LEAF_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [13:0] request_bytes,
	input  logic [12:0] block_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] result_offset,
	output logic [1:0]  status,
	output logic [13:0] bytes_in_use
);
	import bba_pkg::*;

	localparam logic [31:0] REGION = (32'd1 << (LEVELS - 1)) * 32'(LEAF_BYTES);
	localparam int NODES = (1 << LEVELS) - 1;
	localparam int AW = LEVELS;
	localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int OW = (REGION > 32'd1) ? $clog2(REGION) : 1;
	localparam int UW = $clog2(REGION + 32'd1);
	localparam int LENW = LEVELS + 1;

	function automatic logic [31:0] blk(input logic [LVW-1:0] l);
		return REGION >> l;
	endfunction

	function automatic logic [AW-1:0] base(input logic [LVW-1:0] l);
		return AW'((32'd1 << l) - 32'd1);
	endfunction

	function automatic logic [AW-1:0] node_at(input logic [OW-1:0] o, input logic [LVW-1:0] l);
		logic [31:0] n;
		n = ((32'd1 << l) - 32'd1) + ((32'(o) / LEAF_BYTES) >> (32'(LEVELS - 1) - 32'(l)));
		return (n < 32'(NODES)) ? AW'(n) : '0;
	endfunction

	seq_state_t    state_q;
	logic [NODES-1:0] node_free_q;
	logic [NODES-1:0] node_split_q;
	logic [LENW-1:0] len_q [LEVELS];
	logic [UW-1:0] used_q;
	logic [OW-1:0] off_q;
	logic [LVW-1:0] lvl_q;
	logic [LVW-1:0] cur_q;
	logic [LENW-1:0] idx_q;
	logic [1:0]    status_q;
	logic [12:0]   res_off_q;
	logic          out_valid_q;
	logic [12:0]   out_off_q;
	logic [1:0]    out_status_q;
	logic [13:0]   out_used_q;

	logic [LVW-1:0] tgt;
	logic [OW-1:0]  buddy;
	logic [OW-1:0]  upper;
	logic [LVW-1:0] cur_up;
	logic [LVW-1:0] cur_dn;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [OW-1:0]  ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [OW-1:0]  ram_rdata;
	logic [OW-1:0]  pop_off;
	logic           push_room_up;
	logic           push_room_cur;

	always_comb begin
		tgt = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (32'(request_bytes) <= blk(LVW'(l))) begin
				tgt = LVW'(l);
			end
		end
	end

	assign cur_up = cur_q + LVW'(1);
	assign cur_dn = cur_q - LVW'(1);
	assign buddy = off_q ^ OW'(blk(cur_q));
	assign upper = off_q + OW'(blk(cur_up));
	assign push_room_up = 32'(len_q[cur_up]) < (32'd1 << cur_up);
	assign push_room_cur = 32'(len_q[cur_q]) < (32'd1 << cur_q);
	// the root list can only hold offset zero
	assign pop_off = (cur_q == '0) ? '0 : ram_rdata;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_ASRCH: begin
				ram_raddr = base(cur_q) + AW'(len_q[cur_q]) - AW'(1);
			end
			S_ASPLIT: begin
				if (cur_q != lvl_q && push_room_up) begin
					ram_we = 1'b1;
					ram_waddr = base(cur_up) + AW'(len_q[cur_up]);
					ram_wdata = upper;
				end
			end
			S_FMERGE: begin
				if ((cur_q == '0 || !node_free_q[node_at(buddy, cur_q)]) && push_room_cur) begin
					ram_we = 1'b1;
					ram_waddr = base(cur_q) + AW'(len_q[cur_q]);
					ram_wdata = off_q;
				end
			end
			S_FRMRD: begin
				ram_raddr = base(cur_q) + AW'(idx_q);
			end
			S_FSHRD: begin
				ram_raddr = base(cur_q) + AW'(idx_q) + AW'(1);
			end
			S_FSHWR: begin
				ram_we = 1'b1;
				ram_waddr = base(cur_q) + AW'(idx_q);
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	bba_list_ram #(
		.DEPTH(NODES),
		.AW(AW),
		.DW(OW)
	) u_list_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_free_q <= NODES'(1);
			node_split_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				len_q[l] <= (l == 0) ? LENW'(1) : '0;
			end
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_off_q <= block_offset;
						if (command == CMD_ALLOC) begin
							if (32'(request_bytes) > REGION) begin
								status_q <= ST_TOO_LARGE;
								res_off_q <= '0;
								state_q <= S_DONE;
							end else begin
								lvl_q <= tgt;
								cur_q <= tgt;
								state_q <= S_ASRCH;
							end
						end else begin
							off_q <= OW'(block_offset);
							cur_q <= LVW'(LEVELS - 1);
							if (32'(block_offset) >= REGION) begin
								status_q <= ST_BAD_FREE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FLVL;
							end
						end
					end
				end
				S_ASRCH: begin
					if (len_q[cur_q] != '0) begin
						len_q[cur_q] <= len_q[cur_q] - LENW'(1);
						state_q <= S_APOPW;
					end else if (cur_q == '0) begin
						status_q <= ST_NO_BLOCK;
						res_off_q <= '0;
						state_q <= S_DONE;
					end else begin
						cur_q <= cur_dn;
					end
				end
				S_APOPW: begin
					off_q <= pop_off;
					node_free_q[node_at(pop_off, cur_q)] <= 1'b0;
					state_q <= S_ASPLIT;
				end
				S_ASPLIT: begin
					if (cur_q == lvl_q) begin
						used_q <= used_q + UW'(blk(lvl_q));
						res_off_q <= 13'(off_q);
						status_q <= ST_OK;
						state_q <= S_DONE;
					end else begin
						node_split_q[node_at(off_q, cur_q)] <= 1'b1;
						node_free_q[node_at(off_q, cur_up)] <= 1'b0;
						node_split_q[node_at(off_q, cur_up)] <= 1'b0;
						node_free_q[node_at(upper, cur_up)] <= 1'b1;
						node_split_q[node_at(upper, cur_up)] <= 1'b0;
						if (push_room_up) begin
							len_q[cur_up] <= len_q[cur_up] + LENW'(1);
						end
						cur_q <= cur_up;
					end
				end
				S_FLVL: begin
					if (cur_q != '0 && !node_split_q[node_at(off_q, cur_dn)]) begin
						cur_q <= cur_dn;
					end else if ((32'(off_q) % LEAF_BYTES) != 32'd0
						|| ((32'(off_q) / LEAF_BYTES)
						& ((32'd1 << (32'(LEVELS - 1) - 32'(cur_q))) - 32'd1)) != 32'd0
						|| node_free_q[node_at(off_q, cur_q)]
						|| node_split_q[node_at(off_q, cur_q)]) begin
						status_q <= ST_BAD_FREE;
						state_q <= S_DONE;
					end else begin
						used_q <= used_q - UW'(blk(cur_q));
						state_q <= S_FMERGE;
					end
				end
				S_FMERGE: begin
					if (cur_q == '0 || !node_free_q[node_at(buddy, cur_q)]) begin
						node_free_q[node_at(off_q, cur_q)] <= 1'b1;
						if (push_room_cur) begin
							len_q[cur_q] <= len_q[cur_q] + LENW'(1);
						end
						status_q <= ST_OK;
						state_q <= S_DONE;
					end else begin
						node_free_q[node_at(buddy, cur_q)] <= 1'b0;
						idx_q <= '0;
						state_q <= S_FRMRD;
					end
				end
				S_FRMRD: begin
					if (idx_q >= len_q[cur_q]) begin
						state_q <= S_FMFIN;
					end else begin
						state_q <= S_FRMCMP;
					end
				end
				S_FRMCMP: begin
					if (ram_rdata == buddy) begin
						state_q <= S_FSHRD;
					end else begin
						idx_q <= idx_q + LENW'(1);
						state_q <= S_FRMRD;
					end
				end
				S_FSHRD: begin
					if (idx_q + LENW'(1) < len_q[cur_q]) begin
						state_q <= S_FSHWR;
					end else begin
						len_q[cur_q] <= len_q[cur_q] - LENW'(1);
						state_q <= S_FMFIN;
					end
				end
				S_FSHWR: begin
					idx_q <= idx_q + LENW'(1);
					state_q <= S_FSHRD;
				end
				S_FMFIN: begin
					node_free_q[node_at(off_q, cur_q)] <= 1'b0;
					off_q <= (off_q < buddy) ? off_q : buddy;
					node_split_q[node_at(((off_q < buddy) ? off_q : buddy), cur_dn)] <= 1'b0;
					cur_q <= cur_dn;
					state_q <= S_FMERGE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_off_q <= res_off_q;
						out_status_q <= status_q;
						out_used_q <= 14'(used_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign result_offset = out_off_q;
	assign status = out_status_q;
	assign bytes_in_use = out_used_q;

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= REGION)
		else $error("allocated total exceeds region");
	a_root_list: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[0] <= LENW'(1))
		else $error("root free list holds more than one block");
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while request in progress");
	a_root_flags: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !(node_free_q[0] && node_split_q[0]))
		else $error("root both free and split");
`endif

endmodule

[tb/buddy_block_allocator_unit_tb.sv]
// Testbench for buddy_block_allocator_unit: directed table plus random allocate/free traffic,
// each result checked against a behavioral model of the buddy tree kept here.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module buddy_block_allocator_unit_tb;
	import bba_pkg::*;

	localparam int LEVELS = 8;
	localparam int LEAF_BYTES = 32;
	localparam int REGION = (1 << (LEVELS - 1)) * LEAF_BYTES;
	localparam int NODES = (1 << LEVELS) - 1;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [12:0] offset;
		status_t     code;
		logic [13:0] total;
	} alloc_result_t;

	typedef struct {
		cmd_t        cmd;
		logic [13:0] bytes;
		logic [12:0] offset;
		bit          typed;
		alloc_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [13:0] request_bytes = '0;
	logic [12:0] block_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [12:0] result_offset;
	logic [1:0]  status;
	logic [13:0] bytes_in_use;

	buddy_block_allocator_unit #(.LEVELS(LEVELS), .LEAF_BYTES(LEAF_BYTES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .request_bytes(request_bytes), .block_offset(block_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_offset(result_offset), .status(status), .bytes_in_use(bytes_in_use)
	);

	always #4 clk = ~clk;

	// tree state of the model
	bit          tree_free[NODES];
	bit          tree_split[NODES];
	logic [12:0] free_slots[NODES];
	int          free_count[LEVELS];
	int          in_use;

	alloc_result_t pending_results[$];
	logic [12:0]   live_blocks[$];
	int            errors = 0;
	int            cycles = 0;
	bit            stim_done = 1'b0;

	function automatic int block_bytes(int lvl);
		return REGION >> lvl;
	endfunction

	function automatic int node_of(int off, int lvl);
		int n;
		n = (1 << lvl) - 1 + off / block_bytes(lvl);
		return n < NODES ? n : 0;
	endfunction

	function automatic void push_free(int lvl, int v);
		if (free_count[lvl] < (1 << lvl)) begin
			free_slots[(1 << lvl) - 1 + free_count[lvl]] = 13'(v);
			free_count[lvl]++;
		end
	endfunction

	function automatic void drop_free(int lvl, int v);
		int base;
		base = (1 << lvl) - 1;
		for (int i = 0; i < free_count[lvl]; i++) begin
			if (free_slots[base + i] == v) begin
				for (int j = i; j + 1 < free_count[lvl]; j++)
					free_slots[base + j] = free_slots[base + j + 1];
				free_count[lvl]--;
				return;
			end
		end
	endfunction

	function automatic void tree_reset();
		foreach (tree_free[i]) begin
			tree_free[i] = 0;
			tree_split[i] = 0;
			free_slots[i] = '0;
		end
		foreach (free_count[i]) free_count[i] = 0;
		tree_free[0] = 1;
		free_count[0] = 1;
		in_use = 0;
	endfunction

	function automatic alloc_result_t serve_request(cmd_t cmd, int bytes, int off_in);
		alloc_result_t r;
		int lvl, src, off, upper, n, b, buddy, bn;
		r.offset = '0;
		r.code = ST_OK;
		if (cmd == CMD_ALLOC) begin
			if (bytes > REGION) begin
				r.code = ST_TOO_LARGE;
			end else begin
				lvl = LEVELS - 1;
				while (lvl > 0 && bytes > block_bytes(lvl)) lvl--;
				src = lvl;
				while (src >= 0 && free_count[src] == 0) src--;
				if (src < 0) begin
					r.code = ST_NO_BLOCK;
				end else begin
					free_count[src]--;
					off = free_slots[(1 << src) - 1 + free_count[src]];
					tree_free[node_of(off, src)] = 0;
					for (int s = src; s < lvl; s++) begin
						upper = off + block_bytes(s + 1);
						tree_split[node_of(off, s)] = 1;
						tree_free[node_of(off, s + 1)] = 0;
						tree_split[node_of(off, s + 1)] = 0;
						tree_free[node_of(upper, s + 1)] = 1;
						tree_split[node_of(upper, s + 1)] = 0;
						push_free(s + 1, upper);
					end
					in_use += block_bytes(lvl);
					r.offset = 13'(off);
				end
			end
		end else begin
			off = off_in;
			r.offset = 13'(off);
			if (off >= REGION) begin
				r.code = ST_BAD_FREE;
			end else begin
				lvl = LEVELS - 1;
				while (lvl > 0 && !tree_split[node_of(off, lvl - 1)]) lvl--;
				n = node_of(off, lvl);
				if (off % block_bytes(lvl) != 0 || tree_free[n] || tree_split[n]) begin
					r.code = ST_BAD_FREE;
				end else begin
					b = off;
					in_use -= block_bytes(lvl);
					while (lvl > 0) begin
						buddy = b ^ block_bytes(lvl);
						bn = node_of(buddy, lvl);
						if (!tree_free[bn]) break;
						tree_free[bn] = 0;
						drop_free(lvl, buddy);
						tree_free[node_of(b, lvl)] = 0;
						b = b < buddy ? b : buddy;
						lvl--;
						tree_split[node_of(b, lvl)] = 0;
					end
					tree_free[node_of(b, lvl)] = 1;
					push_free(lvl, b);
				end
			end
		end
		r.total = 14'(in_use);
		return r;
	endfunction

	// issue one transfer at the falling edge, hold until accepted
	task automatic send_request(cmd_t cmd, int bytes, int off, bit typed = 0,
			alloc_result_t want = '0);
		alloc_result_t r;
		in_valid <= 1'b1;
		command <= cmd;
		request_bytes <= 14'(bytes);
		block_offset <= 13'(off);
		do @(posedge clk); while (in_stall);
		r = serve_request(cmd, bytes, off);
		if (typed && r != want) begin
			$display("%0t table row disagrees with model: typed %p model %p", $time, want, r);
			errors++;
		end
		pending_results.push_back(r);
		if (cmd == CMD_ALLOC && r.code == ST_OK) live_blocks.push_back(r.offset);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// receiver stall pattern and result check
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (phase % 400 < 100) out_stall <= 1'b0;
			else out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: offset %0d status %0d total %0d",
					$time, result_offset, status, bytes_in_use);
				errors++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (result_offset !== want.offset) begin
					$display("%0t result_offset expected %0d actual %0d",
						$time, want.offset, result_offset);
					errors++;
				end
				if (status !== want.code) begin
					$display("%0t status expected %0d actual %0d", $time, want.code, status);
					errors++;
				end
				if (bytes_in_use !== want.total) begin
					$display("%0t bytes_in_use expected %0d actual %0d",
						$time, want.total, bytes_in_use);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	stim_row_t stim_table[$];

	function automatic stim_row_t row(cmd_t c, int bytes, int off, bit typed = 0,
			int woff = 0, status_t wcode = ST_OK, int wtotal = 0);
		stim_row_t s;
		s.cmd = c;
		s.bytes = 14'(bytes);
		s.offset = 13'(off);
		s.typed = typed;
		s.want.offset = 13'(woff);
		s.want.code = wcode;
		s.want.total = 14'(wtotal);
		return s;
	endfunction

	initial begin
		int idx, burst, pick, lvl;
		tree_reset();
		// oversize, root, leaves, zero bytes, bad frees, merge cascade
		stim_table.push_back(row(CMD_ALLOC, 16383, 0, 1, 0, ST_TOO_LARGE, 0));
		stim_table.push_back(row(CMD_ALLOC, REGION + 1, 0, 1, 0, ST_TOO_LARGE, 0));
		stim_table.push_back(row(CMD_FREE, 0, 0, 1, 0, ST_BAD_FREE, 0));
		stim_table.push_back(row(CMD_FREE, 0, 8191, 1, 8191, ST_BAD_FREE, 0));
		stim_table.push_back(row(CMD_ALLOC, REGION, 0, 1, 0, ST_OK, REGION));
		stim_table.push_back(row(CMD_ALLOC, 0, 0, 1, 0, ST_NO_BLOCK, REGION));
		stim_table.push_back(row(CMD_FREE, 0, 0, 1, 0, ST_OK, 0));
		stim_table.push_back(row(CMD_ALLOC, 0, 0, 1, 0, ST_OK, LEAF_BYTES));
		stim_table.push_back(row(CMD_ALLOC, 1, 0));
		stim_table.push_back(row(CMD_ALLOC, LEAF_BYTES + 1, 0));
		stim_table.push_back(row(CMD_ALLOC, REGION / 2, 0));
		stim_table.push_back(row(CMD_ALLOC, REGION / 2, 0));
		stim_table.push_back(row(CMD_FREE, 0, 16));
		stim_table.push_back(row(CMD_FREE, 0, 0));
		stim_table.push_back(row(CMD_FREE, 0, 0));
		stim_table.push_back(row(CMD_FREE, 0, LEAF_BYTES));
		stim_table.push_back(row(CMD_FREE, 0, 2 * LEAF_BYTES));
		stim_table.push_back(row(CMD_FREE, 0, REGION / 2));
		stim_table.push_back(row(CMD_ALLOC, REGION, 0, 1, 0, ST_OK, REGION));
		stim_table.push_back(row(CMD_FREE, 0, 0, 1, 0, ST_OK, 0));
		stim_table.push_back(row(CMD_ALLOC, 14'h2AAA, 0));
		stim_table.push_back(row(CMD_FREE, 0, 13'h1555));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			send_request(stim_table[i].cmd, stim_table[i].bytes, stim_table[i].offset,
				stim_table[i].typed, stim_table[i].want);
			if ($urandom_range(0, 2) == 0) sender_gap();
		end
		live_blocks.delete();

		idx = 0;
		while (idx < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					// mostly small sizes, sometimes any level, rarely junk
					lvl = $urandom_range(0, 9) < 7 ? $urandom_range(4, LEVELS - 1)
						: $urandom_range(0, LEVELS - 1);
					send_request(CMD_ALLOC, $urandom_range(block_bytes(lvl) / 2 + 1,
						block_bytes(lvl)), $urandom_range(0, 8191));
				end else if (pick < 90 && live_blocks.size() > 0) begin
					int k;
					k = $urandom_range(0, live_blocks.size() - 1);
					send_request(CMD_FREE, $urandom_range(0, 16383), live_blocks[k]);
					live_blocks.delete(k);
				end else if (pick < 95) begin
					send_request(CMD_FREE, $urandom_range(0, 16383), $urandom_range(0, 8191));
				end else begin
					send_request(CMD_ALLOC, $urandom_range(0, 16383), $urandom_range(0, 8191));
				end
				idx++;
			end
			if ($urandom_range(0, 3) != 0) sender_gap();
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/bba_pkg.sv
rtl/core/bba_list_ram.sv
rtl/core/buddy_block_allocator_unit.sv
tb/buddy_block_allocator_unit_tb.sv
